// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files; ple_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ple_pkg.sv =====
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMP_W    = POS_W + 2;
  localparam int OUT_CNT_W = 6;

  typedef enum logic [2:0] {
    FN_READOUT    = 3'd0,
    FN_INS_FRONT  = 3'd1,
    FN_INS_END    = 3'd2,
    FN_INS_POS    = 3'd3,
    FN_DEL_FRONT  = 3'd4,
    FN_DEL_END    = 3'd5,
    FN_DEL_POS    = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_BADPOS = 3'd2,
    STAT_RANGE  = 3'd3,
    STAT_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] last;
  } cell_cmd_t;

endpackage

// ===== sv/ple_cell.sv =====
module ple_cell (
  input  logic                             clk,
  input  logic [ple_pkg::IDX_W-1:0]        cell_index,
  input  ple_pkg::cell_cmd_t               cmd,
  input  logic signed [ple_pkg::DATA_W-1:0] load_value,
  input  logic signed [ple_pkg::DATA_W-1:0] left_data,
  input  logic signed [ple_pkg::DATA_W-1:0] right_data,
  input  logic signed [ple_pkg::DATA_W-1:0] head_data,
  output logic signed [ple_pkg::DATA_W-1:0] data_r
);

  logic signed [ple_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      ple_pkg::CMD_INSERT: begin
        if (cell_index > cmd.idx) begin
          data_nxt = left_data;
        end else if (cell_index == cmd.idx) begin
          data_nxt = load_value;
        end
      end
      ple_pkg::CMD_DELETE: begin
        if (cell_index >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      ple_pkg::CMD_ROTATE: begin
        if (cell_index < cmd.last) begin
          data_nxt = right_data;
        end else if (cell_index == cmd.last) begin
          data_nxt = head_data;
        end
      end
      ple_pkg::CMD_NONE: begin
        data_nxt = data_r;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== sv/ple_ctrl.sv =====
`include "assert_macros.svh"

module ple_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_func,
  input  logic [ple_pkg::POS_W-1:0]           in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]   head_value,
  output ple_pkg::cell_cmd_t                  cmd,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ple_pkg::DATA_W-1:0]   out_item_value,
  output logic [2:0]                          out_status,
  output logic                                out_is_last,
  output logic [ple_pkg::OUT_CNT_W-1:0]       out_element_count
);

  localparam int IdxW = ple_pkg::IDX_W;
  localparam int CntW = ple_pkg::CNT_W;
  localparam int CmpW = ple_pkg::CMP_W;
  localparam int OutW = ple_pkg::OUT_CNT_W;
  localparam int DataW = ple_pkg::DATA_W;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CntW-1:0]          count_r, count_nxt;
  logic [IdxW-1:0]          rd_idx_r, rd_idx_nxt;
  logic                     out_valid_r;
  logic signed [DataW-1:0]  out_item_r, out_item_nxt;
  ple_pkg::status_t         out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [CntW-1:0]          out_count_r;
  logic                     load_out;
  logic                     out_free;
  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  logic [CmpW-1:0]          pos_ext;
  logic [CmpW-1:0]          cnt_ext;
  logic [IdxW-1:0]          pos_idx;
  logic [IdxW-1:0]          last_idx;
  ple_pkg::status_t         status;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign is_full  = count_r >= CntW'(ple_pkg::CAPACITY);
  assign is_empty = count_r == '0;
  assign pos_ext  = CmpW'(in_position);
  assign cnt_ext  = CmpW'(count_r);
  assign pos_idx  = IdxW'(in_position - 1'b1);
  assign last_idx = IdxW'(count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    load_out       = 1'b0;
    out_item_nxt   = '0;
    out_status_nxt = ple_pkg::STAT_OK;
    out_last_nxt   = 1'b1;
    status         = ple_pkg::STAT_OK;
    cmd.op         = ple_pkg::CMD_NONE;
    cmd.idx        = '0;
    cmd.last       = last_idx;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (in_func)
            ple_pkg::FN_READOUT: begin
              if (is_empty) begin
                status = ple_pkg::STAT_EMPTY;
              end else begin
                load_out   = 1'b0;
                state_nxt  = S_READ;
                rd_idx_nxt = '0;
              end
            end
            ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_END: begin
              if (is_full) begin
                status = ple_pkg::STAT_FULL;
              end else begin
                cmd.op    = ple_pkg::CMD_INSERT;
                cmd.idx   = (in_func == ple_pkg::FN_INS_FRONT) ? '0 : IdxW'(count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            ple_pkg::FN_INS_POS: begin
              if (pos_ext == '0) begin
                status = ple_pkg::STAT_BADPOS;
              end else if (is_full) begin
                status = ple_pkg::STAT_FULL;
              end else if (pos_ext > cnt_ext + 1'b1) begin
                status = ple_pkg::STAT_RANGE;
              end else begin
                cmd.op    = ple_pkg::CMD_INSERT;
                cmd.idx   = pos_idx;
                count_nxt = count_r + 1'b1;
              end
            end
            ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_END: begin
              if (is_empty) begin
                status = ple_pkg::STAT_EMPTY;
              end else begin
                cmd.op    = ple_pkg::CMD_DELETE;
                cmd.idx   = (in_func == ple_pkg::FN_DEL_FRONT) ? '0 : last_idx;
                count_nxt = count_r - 1'b1;
              end
            end
            ple_pkg::FN_DEL_POS: begin
              if (is_empty) begin
                status = ple_pkg::STAT_EMPTY;
              end else if (pos_ext == '0) begin
                status = ple_pkg::STAT_BADPOS;
              end else if (pos_ext > cnt_ext) begin
                status = ple_pkg::STAT_RANGE;
              end else begin
                cmd.op    = ple_pkg::CMD_DELETE;
                cmd.idx   = pos_idx;
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              status = ple_pkg::STAT_OK;
            end
          endcase
          out_status_nxt = status;
        end
      end
      S_READ: begin
        if (out_free) begin
          load_out     = 1'b1;
          cmd.op       = ple_pkg::CMD_ROTATE;
          out_item_nxt = head_value;
          out_last_nxt = rd_idx_r == last_idx;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          if (rd_idx_r == last_idx) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (load_out) begin
        out_valid_r  <= 1'b1;
        out_item_r   <= out_item_nxt;
        out_status_r <= out_status_nxt;
        out_last_r   <= out_last_nxt;
        out_count_r  <= count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_value    = out_item_r;
  assign out_status        = out_status_r;
  assign out_is_last       = out_last_r;
  assign out_element_count = OutW'(out_count_r);

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CntW'(ple_pkg::CAPACITY))
  `ASSERT_ALWAYS(a_read_nonempty, clk, rst_n, state_r != S_READ || count_r != '0)
  `ASSERT_NEXT(a_count_held, clk, rst_n, !accept, $stable(count_r))
  `ASSERT_ALWAYS(a_rotate_in_read, clk, rst_n, cmd.op != ple_pkg::CMD_ROTATE || state_r == S_READ)

endmodule

// ===== sv/positional_list_engine_core.sv =====
// Insert and delete requests give their single status word in the cycle after acceptance.
// A readout of n elements enters the read state, then registers one word per cycle while the
// output is not stalled; the input stays stalled until the readout ends and the output is free.
// Throughput is one insert or delete per cycle when the output is not stalled.
// Synchronous active-low reset empties the list; the cell contents are not cleared.
module positional_list_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_func,
  input  logic signed [ple_pkg::DATA_W-1:0]   in_value,
  input  logic [ple_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ple_pkg::DATA_W-1:0]   out_item_value,
  output logic [2:0]                          out_status,
  output logic                                out_is_last,
  output logic [ple_pkg::OUT_CNT_W-1:0]       out_element_count
);

  localparam int IdxW = ple_pkg::IDX_W;

  ple_pkg::cell_cmd_t                cmd;
  logic signed [ple_pkg::DATA_W-1:0] cell_data [ple_pkg::CAPACITY];

  ple_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_position      (in_position),
    .head_value       (cell_data[0]),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_value   (out_item_value),
    .out_status       (out_status),
    .out_is_last      (out_is_last),
    .out_element_count(out_element_count)
  );

  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left_data;
    logic signed [ple_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = in_value;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == ple_pkg::CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    ple_cell u_cell (
      .clk       (clk),
      .cell_index(IdxW'(i)),
      .cmd       (cmd),
      .load_value(in_value),
      .left_data (left_data),
      .right_data(right_data),
      .head_data (cell_data[0]),
      .data_r    (cell_data[i])
    );
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DATA_W    = ple_pkg::DATA_W;
  localparam int POS_W     = ple_pkg::POS_W;
  localparam int OUT_CNT_W = ple_pkg::OUT_CNT_W;
  localparam int CAPACITY  = ple_pkg::CAPACITY;

  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 330;
  localparam int PHASE_LEN = 60;

  typedef struct packed {
    logic signed [DATA_W-1:0] item;
    logic [2:0]               status;
    logic                     last;
    logic [OUT_CNT_W-1:0]     count;
  } list_word_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] cells [CAPACITY];
    int unsigned              fill;
    list_word_t               expected_words [$];
    int                       failures;

    function void clear();
      fill = 0;
      failures = 0;
      expected_words.delete();
    endfunction

    function void push_word(logic signed [DATA_W-1:0] item, ple_pkg::status_t st, logic last);
      list_word_t w;
      w.item = item;
      w.status = st;
      w.last = last;
      w.count = fill[OUT_CNT_W-1:0];
      expected_words.push_back(w);
    endfunction

    function void insert_cell(int unsigned idx, logic signed [DATA_W-1:0] v);
      for (int unsigned i = fill; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      fill++;
    endfunction

    function void remove_cell(int unsigned idx);
      for (int unsigned i = idx; i + 1 < fill; i++) cells[i] = cells[i+1];
      fill--;
    endfunction

    function void note_request(logic [2:0] f, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] p);
      ple_pkg::status_t st;
      st = ple_pkg::STAT_OK;
      case (f)
        ple_pkg::FN_READOUT: begin
          if (fill == 0) begin
            push_word('0, ple_pkg::STAT_EMPTY, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++) begin
              push_word(cells[i], ple_pkg::STAT_OK, i + 1 == fill);
            end
          end
          return;
        end
        ple_pkg::FN_INS_FRONT: begin
          if (fill >= CAPACITY) st = ple_pkg::STAT_FULL;
          else insert_cell(0, v);
        end
        ple_pkg::FN_INS_END: begin
          if (fill >= CAPACITY) st = ple_pkg::STAT_FULL;
          else insert_cell(fill, v);
        end
        ple_pkg::FN_INS_POS: begin
          if (p == 0) st = ple_pkg::STAT_BADPOS;
          else if (fill >= CAPACITY) st = ple_pkg::STAT_FULL;
          else if (p > fill + 1) st = ple_pkg::STAT_RANGE;
          else insert_cell(p - 1, v);
        end
        ple_pkg::FN_DEL_FRONT: begin
          if (fill == 0) st = ple_pkg::STAT_EMPTY;
          else remove_cell(0);
        end
        ple_pkg::FN_DEL_END: begin
          if (fill == 0) st = ple_pkg::STAT_EMPTY;
          else remove_cell(fill - 1);
        end
        ple_pkg::FN_DEL_POS: begin
          if (fill == 0) st = ple_pkg::STAT_EMPTY;
          else if (p == 0) st = ple_pkg::STAT_BADPOS;
          else if (p > fill) st = ple_pkg::STAT_RANGE;
          else remove_cell(p - 1);
        end
        default: begin
        end
      endcase
      push_word('0, st, 1'b1);
    endfunction

    function void check_word(list_word_t got);
      list_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: item_value %0d status %0d", got.item, got.status);
        failures++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.item !== exp_w.item) begin
        $error("item_value: expected %0d, got %0d", exp_w.item, got.item);
        failures++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        failures++;
      end
      if (got.last !== exp_w.last) begin
        $error("is_last: expected %0d, got %0d", exp_w.last, got.last);
        failures++;
      end
      if (got.count !== exp_w.count) begin
        $error("element_count: expected %0d, got %0d", exp_w.count, got.count);
        failures++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_func = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_item_value;
  logic [2:0]               out_status;
  logic                     out_is_last;
  logic [OUT_CNT_W-1:0]     out_element_count;

  list_scoreboard sb;
  bit             quiet = 1'b0;
  int             idle_cycles = 0;

  positional_list_engine_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_value    (out_item_value),
    .out_status        (out_status),
    .out_is_last       (out_is_last),
    .out_element_count (out_element_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 26);
  endfunction

  always @(negedge clk) begin
    out_stall <= idle_now();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_word({out_item_value, out_status, out_is_last, out_element_count});
      end
      if (in_valid && !in_stall) begin
        sb.note_request(in_func, in_value, in_position);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("positional_list_engine_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [2:0] f, input logic signed [DATA_W-1:0] v,
                              input logic [POS_W-1:0] p);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_value <= v;
    in_position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request(input bit grow);
    int          r;
    int unsigned n;
    logic [2:0]  f;
    logic [POS_W-1:0] p;
    r = $urandom_range(0, 99);
    n = sb.fill;
    p = POS_W'($urandom_range(0, 255));
    if (r < 8) begin
      f = ple_pkg::FN_READOUT;
    end else if (r < 10) begin
      f = FN_UNUSED;
    end else if (r < (grow ? 85 : 30)) begin
      case ($urandom_range(0, 2))
        0: f = ple_pkg::FN_INS_FRONT;
        1: f = ple_pkg::FN_INS_END;
        default: f = ple_pkg::FN_INS_POS;
      endcase
      r = $urandom_range(0, 99);
      if (r < 80) p = POS_W'($urandom_range(1, n + 1));
      else if (r < 88) p = '0;
      else if (r < 95) p = POS_W'($urandom_range(n + 2, 255));
    end else begin
      case ($urandom_range(0, 2))
        0: f = ple_pkg::FN_DEL_FRONT;
        1: f = ple_pkg::FN_DEL_END;
        default: f = ple_pkg::FN_DEL_POS;
      endcase
      r = $urandom_range(0, 99);
      if (r < 80) p = (n == 0) ? 8'd1 : POS_W'($urandom_range(1, n));
      else if (r < 88) p = '0;
      else if (r < 95) p = POS_W'($urandom_range(n + 1, 255));
    end
    send_request(f, pick_value(), p);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(ple_pkg::FN_READOUT, 32'sd7, 8'd0);
    send_request(ple_pkg::FN_DEL_FRONT, '0, 8'd0);
    send_request(ple_pkg::FN_DEL_END, '0, 8'd0);
    send_request(ple_pkg::FN_DEL_POS, '0, 8'd0);
    send_request(ple_pkg::FN_DEL_POS, '0, 8'd255);
    send_request(ple_pkg::FN_INS_POS, 32'sd5, 8'd0);
    send_request(ple_pkg::FN_INS_POS, 32'sd5, 8'd2);
    send_request(ple_pkg::FN_INS_POS, 32'sh7fff_ffff, 8'd1);
    send_request(ple_pkg::FN_INS_FRONT, 32'sh8000_0000, 8'd0);
    send_request(ple_pkg::FN_INS_END, -32'sd1, 8'd0);
    send_request(ple_pkg::FN_INS_POS, '0, 8'd4);
    send_request(ple_pkg::FN_INS_POS, 32'sh5555_5555, 8'd2);
    send_request(FN_UNUSED, 32'shaaaa_aaaa, 8'd255);
    send_request(ple_pkg::FN_READOUT, '0, 8'd0);
    send_request(ple_pkg::FN_DEL_POS, '0, 8'd0);
    send_request(ple_pkg::FN_DEL_POS, '0, 8'd6);
    send_request(ple_pkg::FN_DEL_POS, '0, 8'd255);
    send_request(ple_pkg::FN_INS_POS, 32'sd9, 8'd255);
    send_request(ple_pkg::FN_DEL_POS, '0, 8'd3);
    send_request(ple_pkg::FN_DEL_FRONT, '0, 8'd0);
    send_request(ple_pkg::FN_DEL_END, '0, 8'd0);
    send_request(ple_pkg::FN_READOUT, '0, 8'd0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= 130) && (k < 210);
      random_request(((k / PHASE_LEN) % 2) == 0);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", sb.expected_words.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("positional_list_engine_core regression: pass");
    end else begin
      $display("positional_list_engine_core regression: fail");
    end
    $finish;
  end

endmodule
